### design/nsrd_pkg.sv
package nsrd_pkg;

  localparam int DATA_W  = 8;
  localparam int VALUE_W = 64;
  localparam int ID_W    = 5;
  localparam int ERR_W   = 2;
  localparam int LIMIT_W = 17;
  localparam int PHASE_W = 5;
  localparam int IDX_W   = 3;
  localparam int RBL_W   = 17;
  localparam int SBL_W   = 16;
  localparam int TUSER_W = ID_W + ERR_W;

  // parse phases, equal to the field id reported from them
  localparam logic [PHASE_W-1:0] PH_SIZE     = 5'd0;
  localparam logic [PHASE_W-1:0] PH_TYPE     = 5'd1;
  localparam logic [PHASE_W-1:0] PH_DEV      = 5'd2;
  localparam logic [PHASE_W-1:0] PH_QTYPE    = 5'd3;
  localparam logic [PHASE_W-1:0] PH_QVERS    = 5'd4;
  localparam logic [PHASE_W-1:0] PH_QPATH    = 5'd5;
  localparam logic [PHASE_W-1:0] PH_MODE     = 5'd6;
  localparam logic [PHASE_W-1:0] PH_ATIME    = 5'd7;
  localparam logic [PHASE_W-1:0] PH_MTIME    = 5'd8;
  localparam logic [PHASE_W-1:0] PH_LENGTH   = 5'd9;
  localparam logic [PHASE_W-1:0] PH_NAME_LEN = 5'd10;
  localparam logic [PHASE_W-1:0] PH_MUID_LEN = 5'd16;
  localparam logic [PHASE_W-1:0] PH_SKIP     = 5'd18;

  localparam logic [ID_W-1:0] ID_END   = 5'd18;
  localparam logic [ID_W-1:0] ID_ERROR = 5'd19;

  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_TRUNC   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_STRING  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVERRUN = 2'd3;

  localparam logic CFG_NAME_LIMIT  = 1'b0;
  localparam logic CFG_IDENT_LIMIT = 1'b1;

  localparam logic [LIMIT_W-1:0] NAME_LIMIT_RST  = 17'd256;
  localparam logic [LIMIT_W-1:0] IDENT_LIMIT_RST = 17'd64;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              buffer_end;
  } in_word_t;

  // index of the last byte of the field read in a phase
  function automatic logic [IDX_W-1:0] last_index(input logic [PHASE_W-1:0] ph);
    logic [IDX_W-1:0] r;
    case (ph)
      PH_SIZE:   r = 3'd1;
      PH_TYPE:   r = 3'd1;
      PH_DEV:    r = 3'd3;
      PH_QTYPE:  r = 3'd0;
      PH_QVERS:  r = 3'd3;
      PH_QPATH:  r = 3'd7;
      PH_MODE:   r = 3'd3;
      PH_ATIME:  r = 3'd3;
      PH_MTIME:  r = 3'd3;
      PH_LENGTH: r = 3'd7;
      default:   r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

### design/ninep_stat_record_decoder_core.sv
// 9P2000 stat buffer decoder: takes one buffer byte per word (tlast on the buffer's last
// byte) and emits one word per completed field, string count and string byte, an end word
// after skipped extension bytes and an error word (id 19, tlast set) when a record is cut
// short, a string reaches its limit or fields overrun the declared size; after an error the
// rest of the buffer is dropped. Results of a record that later ends in error have already
// been sent and must be discarded downstream. A byte is taken every cycle while the
// two-word input queue has room; the parser handles one byte per cycle, when the output is
// free, into a registered output. The user must write limits through the cfg port (index 0
// name limit, 1 ident limit) only while the block is idle; the block does not enforce it.
module ninep_stat_record_decoder_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [nsrd_pkg::LIMIT_W-1:0] cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // data_byte
  input  logic                         s_tlast,   // buffer_end
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [nsrd_pkg::VALUE_W-1:0] m_tdata,   // field_value
  output logic [nsrd_pkg::TUSER_W-1:0] m_tuser,   // field_id[4:0], error_code[6:5]
  output logic                         m_tlast    // record_last
);

  logic               q_valid;
  logic               q_pop;
  nsrd_pkg::in_word_t q_word;

  nsrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  nsrd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

### design/nsrd_queue.sv
module nsrd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte
  input  logic               s_tlast,   // buffer_end
  output logic               q_valid,
  output nsrd_pkg::in_word_t q_word,
  input  logic               q_pop
);

  nsrd_pkg::in_word_t store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_word   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr].data_byte  <= s_tdata;
      store[wr_ptr].buffer_end <= s_tlast;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### design/nsrd_parser.sv
module nsrd_parser (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic                                   cfg_index,
  input  logic [nsrd_pkg::LIMIT_W-1:0]           cfg_data,
  input  logic                                   q_valid,
  input  nsrd_pkg::in_word_t                     q_word,
  output logic                                   q_pop,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [nsrd_pkg::VALUE_W-1:0]           m_tdata,
  output logic [nsrd_pkg::TUSER_W-1:0]           m_tuser,
  output logic                                   m_tlast
);

  logic [nsrd_pkg::LIMIT_W-1:0] name_limit;
  logic [nsrd_pkg::LIMIT_W-1:0] ident_limit;

  logic [nsrd_pkg::PHASE_W-1:0] parse_phase, parse_phase_next;
  logic [nsrd_pkg::IDX_W-1:0]   field_byte_index, field_byte_index_next;
  logic [nsrd_pkg::VALUE_W-1:0] field_accumulator, field_accumulator_next;
  logic [nsrd_pkg::RBL_W-1:0]   record_bytes_left, record_bytes_left_next;
  logic [nsrd_pkg::SBL_W-1:0]   string_bytes_left, string_bytes_left_next;
  logic                         drain_until_end, drain_until_end_next;

  logic                         advance;
  logic                         rbl_zero;
  logic [nsrd_pkg::RBL_W-1:0]   rbl_dec;
  logic [nsrd_pkg::SBL_W-1:0]   sbl_dec;
  logic                         is_fixed;
  logic                         is_len;
  logic                         field_done;
  logic [nsrd_pkg::VALUE_W-1:0] acc_new;
  logic [nsrd_pkg::SBL_W-1:0]   count_val;
  logic [nsrd_pkg::LIMIT_W-1:0] lim;
  logic [nsrd_pkg::PHASE_W-1:0] str_base;
  logic [nsrd_pkg::PHASE_W-1:0] as_phase;
  logic                         as_close;

  logic                         have;
  logic [nsrd_pkg::ID_W-1:0]    res_id;
  logic [nsrd_pkg::VALUE_W-1:0] res_val;
  logic [nsrd_pkg::ERR_W-1:0]   res_err;
  logic                         res_last;

  assign advance = q_valid && (!m_tvalid || m_tready);
  assign q_pop   = advance;

  assign rbl_zero = (record_bytes_left == '0);
  assign rbl_dec  = (parse_phase != nsrd_pkg::PH_SIZE && !rbl_zero)
                    ? record_bytes_left - 17'd1 : record_bytes_left;
  assign sbl_dec  = (string_bytes_left != '0) ? string_bytes_left - 16'd1 : string_bytes_left;
  assign is_fixed = (parse_phase <= nsrd_pkg::PH_LENGTH);
  assign is_len   = (parse_phase >= nsrd_pkg::PH_NAME_LEN) &&
                    (parse_phase <= nsrd_pkg::PH_MUID_LEN) && !parse_phase[0];
  assign field_done = (field_byte_index == nsrd_pkg::last_index(parse_phase));
  assign acc_new  = field_accumulator |
                    ({{(nsrd_pkg::VALUE_W-nsrd_pkg::DATA_W){1'b0}}, q_word.data_byte}
                     << {field_byte_index, 3'b000});
  assign count_val = acc_new[nsrd_pkg::SBL_W-1:0];
  assign lim = (parse_phase == nsrd_pkg::PH_NAME_LEN) ? name_limit : ident_limit;

  // step past a finished string
  assign str_base = parse_phase[0] ? parse_phase - 5'd1 : parse_phase;
  assign as_close = (str_base >= nsrd_pkg::PH_MUID_LEN) && (rbl_dec == '0);
  assign as_phase = (str_base < nsrd_pkg::PH_MUID_LEN) ? str_base + 5'd2 :
                    (rbl_dec == '0) ? nsrd_pkg::PH_SIZE : nsrd_pkg::PH_SKIP;

  always_comb begin
    parse_phase_next       = parse_phase;
    field_byte_index_next  = field_byte_index;
    field_accumulator_next = field_accumulator;
    record_bytes_left_next = rbl_dec;
    string_bytes_left_next = string_bytes_left;
    drain_until_end_next   = drain_until_end;
    have     = 1'b0;
    res_id   = parse_phase;
    res_val  = '0;
    res_err  = nsrd_pkg::ERR_NONE;
    res_last = 1'b0;
    if (drain_until_end) begin
      record_bytes_left_next = record_bytes_left;
      if (q_word.buffer_end) begin
        parse_phase_next       = nsrd_pkg::PH_SIZE;
        field_byte_index_next  = '0;
        field_accumulator_next = '0;
        record_bytes_left_next = '0;
        string_bytes_left_next = '0;
        drain_until_end_next   = 1'b0;
      end
    end else begin
      if (parse_phase != nsrd_pkg::PH_SIZE && rbl_zero) begin
        res_err = nsrd_pkg::ERR_OVERRUN;
      end else if (is_fixed || is_len) begin
        if (field_done) begin
          field_accumulator_next = '0;
          field_byte_index_next  = '0;
          have    = 1'b1;
          res_val = acc_new;
          if (parse_phase == nsrd_pkg::PH_SIZE) begin
            record_bytes_left_next = {1'b0, count_val};
            parse_phase_next       = nsrd_pkg::PH_TYPE;
          end else if (parse_phase < nsrd_pkg::PH_LENGTH) begin
            parse_phase_next = parse_phase + 5'd1;
          end else if (parse_phase == nsrd_pkg::PH_LENGTH) begin
            parse_phase_next = nsrd_pkg::PH_NAME_LEN;
          end else if ({1'b0, count_val} >= lim) begin
            res_err = nsrd_pkg::ERR_STRING;
          end else if (count_val == '0) begin
            parse_phase_next = as_phase;
            res_last         = as_close;
          end else begin
            string_bytes_left_next = count_val;
            parse_phase_next       = parse_phase + 5'd1;
          end
        end else begin
          field_accumulator_next = acc_new;
          field_byte_index_next  = field_byte_index + 3'd1;
        end
      end else if (parse_phase > nsrd_pkg::PH_NAME_LEN && parse_phase < nsrd_pkg::PH_SKIP) begin
        have    = 1'b1;
        res_val = {{(nsrd_pkg::VALUE_W-nsrd_pkg::DATA_W){1'b0}}, q_word.data_byte};
        string_bytes_left_next = sbl_dec;
        if (sbl_dec == '0) begin
          parse_phase_next = as_phase;
          res_last         = as_close;
        end
      end else begin
        if (rbl_dec == '0) begin
          have             = 1'b1;
          res_id           = nsrd_pkg::ID_END;
          res_last         = 1'b1;
          parse_phase_next = nsrd_pkg::PH_SIZE;
        end
      end
      if (res_err != nsrd_pkg::ERR_NONE) begin
        drain_until_end_next = 1'b1;
      end
      if (q_word.buffer_end) begin
        if (res_err == nsrd_pkg::ERR_NONE &&
            !(parse_phase_next == nsrd_pkg::PH_SIZE && field_byte_index_next == '0)) begin
          res_err = nsrd_pkg::ERR_TRUNC;
        end
        drain_until_end_next = 1'b0;
      end
      if (res_err != nsrd_pkg::ERR_NONE || q_word.buffer_end) begin
        parse_phase_next       = nsrd_pkg::PH_SIZE;
        field_byte_index_next  = '0;
        field_accumulator_next = '0;
        record_bytes_left_next = '0;
        string_bytes_left_next = '0;
      end
      if (res_err != nsrd_pkg::ERR_NONE) begin
        have     = 1'b1;
        res_id   = nsrd_pkg::ID_ERROR;
        res_val  = '0;
        res_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit        <= nsrd_pkg::NAME_LIMIT_RST;
      ident_limit       <= nsrd_pkg::IDENT_LIMIT_RST;
      parse_phase       <= nsrd_pkg::PH_SIZE;
      field_byte_index  <= '0;
      field_accumulator <= '0;
      record_bytes_left <= '0;
      string_bytes_left <= '0;
      drain_until_end   <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == nsrd_pkg::CFG_NAME_LIMIT) name_limit <= cfg_data;
      if (cfg_we && cfg_index == nsrd_pkg::CFG_IDENT_LIMIT) ident_limit <= cfg_data;
      if (advance) begin
        parse_phase       <= parse_phase_next;
        field_byte_index  <= field_byte_index_next;
        field_accumulator <= field_accumulator_next;
        record_bytes_left <= record_bytes_left_next;
        string_bytes_left <= string_bytes_left_next;
        drain_until_end   <= drain_until_end_next;
      end
      if (advance && have) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (advance && have) begin
      m_tdata <= res_val;
      m_tuser <= {res_err, res_id};
      m_tlast <= res_last;
    end
  end

  a_error_closes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[nsrd_pkg::ID_W-1:0] == nsrd_pkg::ID_ERROR
    |-> m_tlast && m_tdata == '0 && m_tuser[nsrd_pkg::TUSER_W-1:nsrd_pkg::ID_W] != nsrd_pkg::ERR_NONE)
    else $error("error word malformed");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[nsrd_pkg::ID_W-1:0] != nsrd_pkg::ID_ERROR
    |-> m_tuser[nsrd_pkg::TUSER_W-1:nsrd_pkg::ID_W] == nsrd_pkg::ERR_NONE)
    else $error("error code on a non-error word");

  a_drain_clean: assert property (@(posedge clk) disable iff (rst)
    drain_until_end |-> parse_phase == nsrd_pkg::PH_SIZE && field_byte_index == '0 &&
                        record_bytes_left == '0)
    else $error("parser state not cleared while draining");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && q_word.buffer_end |=> !drain_until_end && parse_phase == nsrd_pkg::PH_SIZE)
    else $error("buffer end did not restart parser");

endmodule
